// File: hw/rtl/rrsbs_pkg.sv
// Shared types and constants for the round-robin set-bit scanner.
// Used by rrsbs_scan_step and round_robin_set_bit_scanner; depends on nothing.
`default_nettype none

package rrsbs_pkg;

	// Flag word geometry
	localparam int MAX_WORDS  = 4;
	localparam int WORD_W     = 16;
	localparam int FLAG_W     = MAX_WORDS * WORD_W;
	localparam int BIT_IDX_W  = $clog2(WORD_W);
	localparam int WORD_IDX_W = 2;
	localparam int POS_W      = WORD_IDX_W + BIT_IDX_W;
	localparam int NUM_W      = 7;
	localparam int CNT_W      = POS_W;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_W      = 16;
	localparam int WC_W       = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_DIVISOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT      = 2'd1;

	// Scan position: word and bit within the word
	typedef struct packed {
		logic [WORD_IDX_W-1:0] word_idx;
		logic [BIT_IDX_W-1:0]  bit_idx;
	} pos_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/round_robin_set_bit_scanner.sv
// Top level of the round-robin set-bit scanner: prescaler, scan sequencer and output register.
// Depends on rrsbs_pkg and rrsbs_scan_step.
//
// Each accepted word is one tick. A prescaler counts ticks; when the count reaches
// refresh_divisor it clears and, if word_count is 1..4, the block scans the flag words
// cyclically from the bit after the last one reported, one bit per cycle through a single
// step unit, and holds the 1-based number of the first set bit found (0 if none). Every
// tick returns the held number and an update flag. A tick without a scan goes from the
// idle state to the done state; a scan passes the scan state first, examining at most
// 16*word_count bits. in_ready is high only while the sequencer is idle; the output
// register lets the next tick be taken while a result still waits. Writing either
// configuration register clears the scan position, unless a scan step overrides it.
`default_nettype none

module round_robin_set_bit_scanner
	import rrsbs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [FLAG_W-1:0]     flag_bits,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [NUM_W-1:0]           enum_number,
	output logic                       updated,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	state_t            state_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [WC_W-1:0]   wc_q;
	logic [DIV_W-1:0]  tick_q;
	pos_t              pos_q;
	logic [NUM_W-1:0]  held_q;
	logic              upd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [FLAG_W-1:0] flags_q;
	logic [NUM_W-1:0]  out_number_q;
	logic              out_updated_q;

	logic [DIV_W-1:0]  tick_next;
	logic              scan_due;
	logic              wc_ok;
	logic              scan_last;
	logic              out_load;
	pos_t              step_pos;
	logic              step_hit;
	logic [NUM_W-1:0]  step_number;

	// Shared step unit
	rrsbs_scan_step u_step (
		.flags      (flags_q),
		.pos_cur    (pos_q),
		.word_count (wc_q),
		.pos_next   (step_pos),
		.hit        (step_hit),
		.number     (step_number)
	);

	// Prescaler and scan bounds
	assign tick_next = tick_q + DIV_W'(1);
	assign scan_due  = (tick_next >= divisor_q);
	assign wc_ok     = (wc_q != '0) && (wc_q <= WC_W'(MAX_WORDS));
	assign scan_last = ({1'b0, cnt_q} == ({wc_q, 4'b0000} - 7'd1));
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign enum_number = out_number_q;
	assign updated     = out_updated_q;

	// Sequencer, configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			divisor_q   <= DIV_W'(1);
			wc_q        <= WC_W'(1);
			tick_q      <= '0;
			pos_q       <= '0;
			held_q      <= '0;
			upd_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the result once taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Writes to either register clear the scan position, unless a scan step overrides it
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_REFRESH_DIVISOR: begin
						divisor_q <= cfg_data[DIV_W-1:0];
						pos_q     <= '0;
					end
					CFG_WORD_COUNT: begin
						wc_q  <= cfg_data[WC_W-1:0];
						pos_q <= '0;
					end
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						upd_q <= 1'b0;
						cnt_q <= '0;
						if (scan_due) begin
							tick_q <= '0;
							if (wc_ok) begin
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							tick_q  <= tick_next;
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					// Advance one bit per cycle until a hit or a full circle
					pos_q <= step_pos;
					cnt_q <= cnt_q + CNT_W'(1);
					if (step_hit) begin
						held_q  <= step_number;
						upd_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (scan_last) begin
						held_q  <= '0;
						upd_q   <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the flags of the accepted word and the result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			flags_q <= flag_bits;
		end
		if (out_load) begin
			out_number_q  <= held_q;
			out_updated_q <= upd_q;
		end
	end

	// Scan never runs past one full circle of the active words
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, cnt_q} < {wc_q, 4'b0000}))
		else $error("scan counter beyond one circle");

	// After a scan the position lies within the active words
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && upd_q) |-> ({1'b0, pos_q.word_idx} < wc_q))
		else $error("scan position outside active words");

	// An accepted word always leaves the idle state
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("accepted word not processed");

endmodule

`default_nettype wire

// File: hw/rtl/rrsbs_scan_step.sv
// One step of the cyclic bit scan: advance the position by one bit and test it.
// Depends on rrsbs_pkg.
`default_nettype none

module rrsbs_scan_step
	import rrsbs_pkg::*;
(
	input  wire logic [FLAG_W-1:0] flags,
	input  wire pos_t              pos_cur,
	input  wire logic [WC_W-1:0]   word_count,
	output pos_t                   pos_next,
	output logic                   hit,
	output logic [NUM_W-1:0]       number
);

	logic [BIT_IDX_W-1:0]  bit_inc;
	logic [WORD_IDX_W-1:0] word_inc;

	// Advance the bit; on wrap move to the next word, restarting past the last active one
	always_comb begin
		bit_inc  = pos_cur.bit_idx + BIT_IDX_W'(1);
		word_inc = pos_cur.word_idx + WORD_IDX_W'(1);
		pos_next = pos_cur;
		pos_next.bit_idx = bit_inc;
		if (bit_inc == '0) begin
			if ({1'b0, word_inc} >= word_count) begin
				pos_next.word_idx = '0;
			end else begin
				pos_next.word_idx = word_inc;
			end
		end
	end

	// Test the new position and form its 1-based number
	assign hit    = flags[pos_next];
	assign number = NUM_W'({1'b0, pos_next}) + NUM_W'(1);

endmodule

`default_nettype wire

// File: tb/rrsbs_checker.sv
// Checker for the round-robin set-bit scanner: watches the tick, result and register ports,
// predicts each result word and compares it with what the block returns.
// Depends on rrsbs_pkg only.

module rrsbs_checker
	import rrsbs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic [FLAG_W-1:0]     flag_bits,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic [NUM_W-1:0]      enum_number,
	input  wire logic                  updated,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         checked,
	output int                         scans_seen
);

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic             upd;
	} tick_result_t;

	// Expected result words, oldest first
	tick_result_t due_q[$];

	// Shadow of the block's registers and state
	logic [DIV_W-1:0]      divisor;
	logic [WC_W-1:0]       words_on;
	logic [DIV_W-1:0]      ticks;
	logic [BIT_IDX_W-1:0]  pos_bit;
	logic [WORD_IDX_W-1:0] pos_word;
	logic [NUM_W-1:0]      held;

	int fails;
	int seen;
	int scans;

	// Advance the prescaler by one tick and, when it fires, scan for the next set flag
	function automatic tick_result_t next_tick(input logic [FLAG_W-1:0] flags);
		tick_result_t r;
		int           n;
		int           i;
		logic         found;
		n     = int'(words_on);
		r.upd = 1'b0;
		found = 1'b0;
		ticks = ticks + 1'b1;
		if (ticks >= divisor) begin
			ticks = '0;
			if (n != 0 && n <= MAX_WORDS) begin
				r.upd = 1'b1;
				for (i = 0; i < WORD_W * n && !found; i++) begin
					pos_bit = pos_bit + 1'b1;
					// bit wrapped: move to the next active word, back to word 0 past the last
					if (pos_bit == '0) begin
						pos_word = pos_word + 1'b1;
						if (int'(pos_word) > n - 1)
							pos_word = '0;
					end
					if (flags[{pos_word, pos_bit}]) begin
						held  = NUM_W'({pos_word, pos_bit}) + NUM_W'(1);
						found = 1'b1;
					end
				end
				// full circle with nothing set
				if (!found)
					held = '0;
			end
		end
		r.number = held;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		if (!arst_n) begin
			divisor  = DIV_W'(1);
			words_on = WC_W'(1);
			ticks    = '0;
			pos_bit  = '0;
			pos_word = '0;
			held     = '0;
			due_q.delete();
			fails = 0;
			seen  = 0;
			scans = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
			scans_seen <= 0;
		end else begin
			// Compare the outgoing result word with the oldest expectation
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					$error("unexpected result word: enum_number=%0d updated=%0b",
						enum_number, updated);
					fails++;
				end else begin
					want = due_q.pop_front();
					seen++;
					if (enum_number !== want.number) begin
						$error("enum_number: expected %0d, actual %0d", want.number, enum_number);
						fails++;
					end
					if (updated !== want.upd) begin
						$error("updated: expected %0b, actual %0b", want.upd, updated);
						fails++;
					end
				end
			end
			// Track register writes; either known register clears the scan position
			if (cfg_we) begin
				case (cfg_index)
					CFG_REFRESH_DIVISOR: begin
						divisor  = cfg_data[DIV_W-1:0];
						pos_bit  = '0;
						pos_word = '0;
					end
					CFG_WORD_COUNT: begin
						words_on = cfg_data[WC_W-1:0];
						pos_bit  = '0;
						pos_word = '0;
					end
					default: begin
					end
				endcase
			end
			// Predict the result of each accepted tick word
			if (in_valid && in_ready) begin
				want = next_tick(flag_bits);
				if (want.upd)
					scans++;
				due_q.push_back(want);
			end
			fail_count <= fails;
			pending    <= due_q.size();
			checked    <= seen;
			scans_seen <= scans;
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the scanner testbench: clock, reset, tick and register stimulus, result back-pressure.
// Depends on rrsbs_pkg, round_robin_set_bit_scanner and rrsbs_checker.

module tb_top;
	import rrsbs_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASES       = 10;
	localparam int PHASE_TICKS  = 200;

	// Register indexes that select no register
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [FLAG_W-1:0]     flag_bits = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [NUM_W-1:0]      enum_number;
	logic                  updated;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int fail_count;
	int pending;
	int checked;
	int scans_seen;

	int   ticks_sent  = 0;
	int   cfg_writes  = 0;
	logic tx_calm     = 1'b0;
	logic rx_calm     = 1'b0;
	int   hold_asks   = 0;
	int   hold_served = 0;
	int   hold_left   = 0;

	round_robin_set_bit_scanner dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.flag_bits   (flag_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.enum_number (enum_number),
		.updated     (updated),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	rrsbs_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.flag_bits   (flag_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.enum_number (enum_number),
		.updated     (updated),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.scans_seen  (scans_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: random back-pressure, calm stretches and one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_served != hold_asks) begin
			hold_served <= hold_asks;
			hold_left   <= HOLD_CYCLES;
			out_ready   <= 1'b0;
		end else if (rx_calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 29);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
				stall = 0;
			else
				stall++;
		end
		$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
			STALL_LIMIT, pending);
		$display("RESULT: ERROR");
		$finish;
	end

	// Offer one tick word, with random idle cycles ahead of it, and hold it until taken
	task automatic send_tick(input logic [FLAG_W-1:0] flags);
		while (!tx_calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		flag_bits <= flags;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
	endtask

	// Stop offering and wait until every expected result word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write one register once the block has gone quiet
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	// Flag patterns: empty, full, single bits, sparse and dense random
	function automatic logic [FLAG_W-1:0] pick_flags();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		else if (r < 14)
			return '1;
		else if (r < 34)
			return FLAG_W'(1) << $urandom_range(FLAG_W - 1);
		else if (r < 50)
			return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
		else
			return {$urandom, $urandom};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_divisor();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 40)
			return CFG_DATA_W'(1);
		else if (r < 75)
			return CFG_DATA_W'($urandom_range(2, 6));
		else if (r < 95)
			return CFG_DATA_W'($urandom_range(7, 40));
		else
			return '1;
	endfunction

	// Word count in the low bits, random junk above them
	function automatic logic [CFG_DATA_W-1:0] pick_word_count();
		int          r;
		logic [WC_W-1:0] wc;
		r = $urandom_range(99);
		if (r < 8)
			wc = '0;
		else if (r < 14)
			wc = WC_W'($urandom_range(MAX_WORDS + 1, 7));
		else
			wc = WC_W'($urandom_range(1, MAX_WORDS));
		return {(CFG_DATA_W - WC_W)'($urandom), wc};
	endfunction

	initial begin
		int p;
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one word, scan every tick
		send_tick('0);
		send_tick('1);
		send_tick('1);
		send_tick(64'h0000_0000_0000_0001);
		send_tick(64'h0000_0000_0000_8000);
		// flags only outside the active word: nothing found
		send_tick(64'hFFFF_0000_0000_0000);

		// Four words: top bit, the same bit again after a full circle, wrap to word 0
		write_reg(CFG_WORD_COUNT, CFG_DATA_W'(4));
		send_tick(64'h8000_0000_0000_0000);
		send_tick(64'h8000_0000_0000_0000);
		send_tick(64'h0000_0000_0000_0001);
		send_tick('1);
		send_tick(64'h0001_0000_0000_0000);

		// Invalid word counts hold the output
		write_reg(CFG_WORD_COUNT, '0);
		send_tick('1);
		write_reg(CFG_WORD_COUNT, CFG_DATA_W'(7));
		send_tick('1);

		// Two words: flags only in the inactive words, then one in word 1
		write_reg(CFG_WORD_COUNT, CFG_DATA_W'(2));
		send_tick(64'hFFFF_FFFF_0000_0000);
		send_tick(64'h0000_0000_0001_0000);

		// Prescaler extremes
		write_reg(CFG_REFRESH_DIVISOR, '0);
		send_tick('1);
		send_tick('1);
		write_reg(CFG_REFRESH_DIVISOR, CFG_DATA_W'(3));
		for (k = 0; k < 6; k++)
			send_tick(pick_flags());
		write_reg(CFG_REFRESH_DIVISOR, '1);
		send_tick('1);
		send_tick('1);

		// Writes to unused indexes change nothing
		write_reg(CFG_SPARE_A, '1);
		write_reg(CFG_SPARE_B, '0);

		// Random phases, each under its own register settings
		for (p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				write_reg(CFG_REFRESH_DIVISOR, CFG_DATA_W'(1));
				write_reg(CFG_WORD_COUNT, CFG_DATA_W'(MAX_WORDS));
			end else if ($urandom_range(1)) begin
				write_reg(CFG_REFRESH_DIVISOR, pick_divisor());
				write_reg(CFG_WORD_COUNT, pick_word_count());
			end else begin
				write_reg(CFG_WORD_COUNT, pick_word_count());
				write_reg(CFG_REFRESH_DIVISOR, pick_divisor());
			end
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
			tx_calm = (p == 4);
			rx_calm <= (p == 4);
			for (k = 0; k < PHASE_TICKS; k++) begin
				// long receiver hold-off while ticks keep coming
				if (p == 2 && k == PHASE_TICKS / 2)
					hold_asks <= hold_asks + 1;
				// sender pause until everything is back
				if (p == 6 && k == PHASE_TICKS / 2)
					wait_drained();
				send_tick(pick_flags());
			end
		end
		tx_calm = 1'b0;
		rx_calm <= 1'b0;

		// Drain and let any stray result word show up
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d ticks over %0d register writes: %0d results checked, %0d scans",
			ticks_sent, cfg_writes, checked, scans_seen);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
